@@ src/pvm_pkg.sv @@
// ----------------------------------------------------------------------------
// pvm_pkg: shared types and constants of the panned voice mixer
// command codes, controller command/status structs
// ----------------------------------------------------------------------------
`default_nettype none
package pvm_pkg;
	typedef enum logic [1:0] {
		CMD_PLAY   = 2'd0,
		CMD_STOP   = 2'd1,
		CMD_RENDER = 2'd2,
		CMD_WRITE  = 2'd3
	} cmd_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch the command item
		logic play;      // store new voice
		logic stop;      // clear all voices
		logic wr;        // write wave word
		logic clr_sum;   // clear accumulators
		logic visit;     // check current voice, issue left read
		logic rd_right;  // issue right read
		logic mac_left;  // accumulate left product
		logic mac_right; // accumulate right product
		logic next;      // advance voice pointer
		logic finish;    // saturate and present result
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic sound;     // current voice contributes this frame
		logic stereo_o;  // stereo output mixing
		logic last;      // current voice is the last one
	} sts_t;
endpackage
`default_nettype wire

@@ src/pvm_ctrl.sv @@
// ----------------------------------------------------------------------------
// pvm_ctrl: sequencer of the mixer
// walks the voice table for a render, one-shot steps for other commands
// ----------------------------------------------------------------------------
`default_nettype none
module pvm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    command,
	output logic               busy,
	output pvm_pkg::ctl_t      ctl,
	input  pvm_pkg::sts_t      sts
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_EXEC  = 8'b0000_0010,
		S_VISIT = 8'b0000_0100,
		S_RDR   = 8'b0000_1000,
		S_MACL  = 8'b0001_0000,
		S_MACR  = 8'b0010_0000,
		S_FIN   = 8'b0100_0000,
		S_NEXT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [1:0] cmd_q;
	logic stereo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= 2'd0;
			stereo_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (start) begin
					cmd_q <= command;
					state_q <= S_EXEC;
				end
				S_EXEC: state_q <= (cmd_q == pvm_pkg::CMD_RENDER) ? S_VISIT : S_FIN;
				S_VISIT: begin
					stereo_q <= sts.stereo_o;
					if (sts.sound) state_q <= S_RDR;
					else state_q <= sts.last ? S_FIN : S_VISIT;
				end
				S_RDR: state_q <= S_MACL;
				S_MACL: state_q <= stereo_q ? S_MACR : S_NEXT;
				S_MACR: state_q <= S_NEXT;
				S_NEXT: state_q <= sts.last ? S_FIN : S_VISIT;
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctl = '0;
		ctl.load = (state_q == S_IDLE) && start;
		ctl.clr_sum = ctl.load;
		ctl.play = (state_q == S_EXEC) && (cmd_q == pvm_pkg::CMD_PLAY);
		ctl.stop = (state_q == S_EXEC) && (cmd_q == pvm_pkg::CMD_STOP);
		ctl.wr = (state_q == S_EXEC) && (cmd_q == pvm_pkg::CMD_WRITE);
		ctl.visit = (state_q == S_VISIT);
		// left word sits in the read register during the left mac, right word follows
		ctl.rd_right = (state_q == S_MACL);
		ctl.mac_left = (state_q == S_MACL);
		ctl.mac_right = (state_q == S_MACR);
		ctl.next = (state_q == S_NEXT) || ((state_q == S_VISIT) && !sts.sound);
		ctl.finish = (state_q == S_FIN);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> (state_q == S_IDLE))
		else $error("finish not followed by idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> (state_q == S_EXEC))
		else $error("accepted item did not start");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MACR) |-> $past(state_q == S_MACL))
		else $error("right mac out of order");
endmodule
`default_nettype wire

@@ src/pvm_datapath.sv @@
// ----------------------------------------------------------------------------
// pvm_datapath: voice table, wave memory, gain multiplier and accumulators
// ----------------------------------------------------------------------------
`default_nettype none
module pvm_datapath #(
	parameter int VOICE_COUNT = 16,
	parameter int WAVE_WORDS = 65536
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  pvm_pkg::ctl_t           ctl,
	output pvm_pkg::sts_t           sts,
	input  wire logic [1:0]         chan_cfg,
	input  wire logic [31:0]        frame_index,
	input  wire logic [15:0]        wave_address,
	input  wire logic [16:0]        wave_frames,
	input  wire logic               wave_is_stereo,
	input  wire logic [31:0]        start_at_frame,
	input  wire logic [15:0]        voice_gain,
	input  wire logic signed [15:0] pan_position,
	input  wire logic               loop_enable,
	input  wire logic signed [15:0] wave_word,
	output logic signed [15:0]      left_sample,
	output logic signed [15:0]      right_sample,
	output logic [4:0]              active_voice_count,
	output logic                    clipped,
	output logic                    done
);
	localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int AW = $clog2(WAVE_WORDS);
	localparam int CW = $clog2(VOICE_COUNT + 1);
	// sum of up to VOICE_COUNT contributions of 19 bits each
	localparam int SW = 19 + CW;

	// latched item
	logic [31:0] frame_q, start_q;
	logic [15:0] addr_q, gain_q, word_q;
	logic signed [15:0] pan_q;
	logic [16:0] frames_q;
	logic ster_q, loop_q;

	logic [15:0] base_q [VOICE_COUNT];
	logic [16:0] len_q [VOICE_COUNT];
	logic [16:0] cur_q [VOICE_COUNT];
	logic [31:0] vstart_q [VOICE_COUNT];
	logic [15:0] lg_q [VOICE_COUNT];
	logic [15:0] rg_q [VOICE_COUNT];
	logic [VOICE_COUNT-1:0] vster_q, vloop_q, act_q;
	logic [VW-1:0] steal_q, vp_q;

	logic [15:0] mem [WAVE_WORDS];
	logic [15:0] rd_q;

	logic signed [SW-1:0] suml_q, sumr_q;
	logic [16:0] vcur_q;  // cursor used for the current fetch
	logic [VW-1:0] vsel_q;

	// free slot search
	logic [VW-1:0] free_idx;
	logic any_free;
	always_comb begin
		free_idx = '0;
		any_free = 1'b0;
		for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
			if (!act_q[i]) begin
				free_idx = VW'(i);
				any_free = 1'b1;
			end
		end
	end
	logic [VW-1:0] slot;
	assign slot = any_free ? free_idx : steal_q;

	// pan law gains
	logic [15:0] lf, rf;
	logic [31:0] lprod, rprod;
	assign lf = pan_q[15] ? 16'd0 : pan_q;
	assign rf = pan_q[15] ? 16'(-pan_q) : 16'd0;
	assign lprod = gain_q * (32'd32768 - 32'(lf));
	assign rprod = gain_q * (32'd32768 - 32'(rf));

	// current voice state
	logic cur_end, sound;
	logic [16:0] use_cur;
	assign cur_end = (cur_q[vp_q] >= len_q[vp_q]);
	assign sound = act_q[vp_q] && (frame_q >= vstart_q[vp_q]) && (!cur_end || vloop_q[vp_q]);
	assign use_cur = cur_end ? 17'd0 : cur_q[vp_q];

	logic [AW-1:0] raddr;
	logic [17:0] off;
	always_comb begin
		off = vster_q[vsel_q] ? {vcur_q, 1'b0} : {1'b0, vcur_q};
		raddr = AW'(18'(base_q[vsel_q]) + off + (ctl.rd_right && vster_q[vsel_q] ? 18'd1 : 18'd0));
		if (ctl.visit) begin
			off = vster_q[vp_q] ? {use_cur, 1'b0} : {1'b0, use_cur};
			raddr = AW'(18'(base_q[vp_q]) + off);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) mem[AW'(addr_q)] <= word_q;
		rd_q <= mem[raddr];
	end

	// multiplier: sample x gain, floor shift 14
	logic signed [32:0] prod;
	logic signed [15:0] gsel;
	assign gsel = ctl.mac_left ? lg_q[vsel_q] : rg_q[vsel_q];
	assign prod = $signed(rd_q) * $signed({1'b0, gsel});
	logic signed [18:0] contrib;
	assign contrib = 19'(prod >>> 14);

	logic so;
	assign so = chan_cfg[1];
	assign sts.sound = sound;
	assign sts.stereo_o = so;
	assign sts.last = (vp_q == VW'(VOICE_COUNT - 1));

	// saturation
	logic signed [15:0] satl, satr;
	logic cl, cr;
	always_comb begin
		cl = (suml_q > SW'(32767)) || (suml_q < SW'(-32768));
		cr = so && ((sumr_q > SW'(32767)) || (sumr_q < SW'(-32768)));
		satl = (suml_q > SW'(32767)) ? 16'sh7fff :
			(suml_q < SW'(-32768)) ? 16'sh8000 : 16'(suml_q);
		satr = !so ? 16'sd0 : (sumr_q > SW'(32767)) ? 16'sh7fff :
			(sumr_q < SW'(-32768)) ? 16'sh8000 : 16'(sumr_q);
	end

	logic [CW-1:0] cnt;
	always_comb begin
		cnt = '0;
		for (int i = 0; i < VOICE_COUNT; i++) cnt = cnt + CW'(act_q[i]);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			frame_q <= frame_index; start_q <= start_at_frame; addr_q <= wave_address;
			gain_q <= voice_gain; pan_q <= pan_position; frames_q <= wave_frames;
			ster_q <= wave_is_stereo; loop_q <= loop_enable; word_q <= wave_word;
		end
		if (ctl.clr_sum) begin
			suml_q <= '0; sumr_q <= '0;
		end
		if (ctl.mac_left) suml_q <= suml_q + SW'(contrib);
		if (ctl.mac_right) sumr_q <= sumr_q + SW'(contrib);
		if (ctl.visit) begin
			vcur_q <= use_cur; vsel_q <= vp_q;
		end
		if (ctl.play) begin
			base_q[slot] <= addr_q; len_q[slot] <= frames_q; vster_q[slot] <= ster_q;
			vstart_q[slot] <= start_q; cur_q[slot] <= '0; vloop_q[slot] <= loop_q;
			lg_q[slot] <= lprod[30:15]; rg_q[slot] <= rprod[30:15];
		end
		if (ctl.visit && sound) cur_q[vp_q] <= use_cur + 17'd1;
		if (ctl.finish) begin
			left_sample <= satl;
			right_sample <= satr;
			clipped <= cl || cr;
			active_voice_count <= 5'(cnt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0; steal_q <= '0; vp_q <= '0; done <= 1'b0;
		end else begin
			done <= ctl.finish;
			if (ctl.play) begin
				act_q[slot] <= 1'b1;
				if (!any_free)
					steal_q <= (steal_q == VW'(VOICE_COUNT - 1)) ? '0 : steal_q + VW'(1);
			end
			if (ctl.stop) act_q <= '0;
			if (ctl.visit && act_q[vp_q] && frame_q >= vstart_q[vp_q] && cur_end && !vloop_q[vp_q])
				act_q[vp_q] <= 1'b0;
			if (ctl.next) vp_q <= sts.last ? '0 : vp_q + VW'(1);
		end
	end
endmodule
`default_nettype wire

@@ src/panned_voice_mixer_unit.sv @@
// ----------------------------------------------------------------------------
// panned_voice_mixer_unit: sample playback mixer with panned voices
// play, stop, render and wave write commands, one result per command
// ----------------------------------------------------------------------------
// play, stop and write run the exec and finish states before the strobe;
// render visits every voice; each sounding voice adds a wave read and a left
// mac, plus a right mac for stereo out, via the single multiplier and wave port
// throughput: one command at a time, busy high until the strobe cycle ends
// reset: all voices idle, steal pointer zero, two output channels; wave
//   memory holds no reset value, the receiver cannot stall results
`default_nettype none
module panned_voice_mixer_unit #(
	parameter int VOICE_COUNT = 16,
	parameter int WAVE_WORDS = 65536
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         command,
	input  wire logic [31:0]        frame_index,
	input  wire logic [15:0]        wave_address,
	input  wire logic [16:0]        wave_frames,
	input  wire logic               wave_is_stereo,
	input  wire logic [31:0]        start_at_frame,
	input  wire logic [15:0]        voice_gain,
	input  wire logic signed [15:0] pan_position,
	input  wire logic               loop_enable,
	input  wire logic signed [15:0] wave_word,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_data,
	output logic                    result_valid,
	output logic signed [15:0]      left_sample,
	output logic signed [15:0]      right_sample,
	output logic [4:0]              active_voice_count,
	output logic                    clipped
);
	pvm_pkg::ctl_t ctl;
	pvm_pkg::sts_t sts;
	logic busy_c;
	logic [1:0] chan_q;

	// output channel register, taken any time
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) chan_q <= 2'd2;
		else if (cfg_valid) chan_q <= cfg_data;
	end

	// no transaction is taken during the strobe cycle
	pvm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start && !result_valid), .command(command),
		.busy(busy_c), .ctl(ctl), .sts(sts)
	);

	pvm_datapath #(.VOICE_COUNT(VOICE_COUNT), .WAVE_WORDS(WAVE_WORDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .chan_cfg(chan_q),
		.frame_index(frame_index), .wave_address(wave_address),
		.wave_frames(wave_frames), .wave_is_stereo(wave_is_stereo),
		.start_at_frame(start_at_frame), .voice_gain(voice_gain),
		.pan_position(pan_position), .loop_enable(loop_enable),
		.wave_word(wave_word), .left_sample(left_sample),
		.right_sample(right_sample), .active_voice_count(active_voice_count),
		.clipped(clipped), .done(result_valid)
	);

	// busy covers the strobe cycle too
	assign busy = busy_c || result_valid;
endmodule
`default_nettype wire

@@ tb/panned_voice_mixer_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// panned_voice_mixer_unit_tb: self-checking bench for the panned voice mixer
// drives play, stop, render and wave write commands through the start/busy
// port and predicts every result with a cycle-free model of the voice table;
// the channel register is swept between phases while the block is idle
// ----------------------------------------------------------------------------
`default_nettype none
module panned_voice_mixer_unit_tb;

	localparam int VOICES = 16;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 120;

	typedef struct {
		pvm_pkg::cmd_t      command;
		logic [31:0]        frame_index;
		logic [15:0]        wave_address;
		logic [16:0]        wave_frames;
		logic               wave_is_stereo;
		logic [31:0]        start_at_frame;
		logic [15:0]        voice_gain;
		logic signed [15:0] pan_position;
		logic               loop_enable;
		logic signed [15:0] wave_word;
	} mixer_cmd_t;

	typedef struct {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic [4:0]         active_voice_count;
		logic               clipped;
	} mix_frame_t;

	// dut ports
	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         command;
	logic [31:0]        frame_index;
	logic [15:0]        wave_address;
	logic [16:0]        wave_frames;
	logic               wave_is_stereo;
	logic [31:0]        start_at_frame;
	logic [15:0]        voice_gain;
	logic signed [15:0] pan_position;
	logic               loop_enable;
	logic signed [15:0] wave_word;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_data;
	logic               result_valid;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic [4:0]         active_voice_count;
	logic               clipped;

	panned_voice_mixer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.frame_index(frame_index),
		.wave_address(wave_address),
		.wave_frames(wave_frames),
		.wave_is_stereo(wave_is_stereo),
		.start_at_frame(start_at_frame),
		.voice_gain(voice_gain),
		.pan_position(pan_position),
		.loop_enable(loop_enable),
		.wave_word(wave_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.active_voice_count(active_voice_count),
		.clipped(clipped)
	);

	// shadow copy of the mixer state
	logic [15:0] wave_mem [65536];
	bit          wave_written [65536];
	logic [15:0] v_base [VOICES];
	logic [16:0] v_length [VOICES];
	logic        v_stereo [VOICES];
	logic [31:0] v_start [VOICES];
	logic [16:0] v_cursor [VOICES];
	logic [15:0] v_left_gain [VOICES];
	logic [15:0] v_right_gain [VOICES];
	logic        v_loop [VOICES];
	logic        v_active [VOICES];
	logic [3:0]  steal_ptr;
	logic [1:0]  out_channels;

	mix_frame_t pending_frames [$];

	int  mismatches;
	int  n_play, n_stop, n_render, n_write, n_steal, n_clip;
	bit  allow_gaps;
	int  quiet_cycles;
	logic [31:0] play_head;   // frame counter used by render commands

	// ------------------------------------------------------------------
	// clock and watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// any transaction on any port restarts the count
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic logic [15:0] wave_addr_of(int v, logic [16:0] cur, int lane);
		int span;
		span = v_stereo[v] ? 2 : 1;
		return 16'(int'(v_base[v]) + int'(cur) * span + lane);
	endfunction

	function automatic logic signed [15:0] clamp16(longint acc, ref bit clip);
		if (acc > 32767) begin
			clip = 1'b1;
			return 16'sh7fff;
		end
		if (acc < -32768) begin
			clip = 1'b1;
			return -16'sh8000;
		end
		return 16'(acc);
	endfunction

	function automatic mix_frame_t mix_command(mixer_cmd_t it);
		mix_frame_t r;
		longint acc [2];
		int slot, lf, rf, nch, gain, cnt;
		longint smp, g;
		logic [15:0] a;
		bit clip;
		r = '{default: '0};
		acc[0] = 0;
		acc[1] = 0;
		clip = 1'b0;
		case (it.command)
			pvm_pkg::CMD_PLAY: begin
				slot = -1;
				for (int v = 0; v < VOICES; v++)
					if (slot < 0 && !v_active[v]) slot = v;
				if (slot < 0) begin
					slot = steal_ptr;
					steal_ptr = steal_ptr + 4'd1;
					n_steal++;
				end
				gain = it.voice_gain;
				// pan law: only the far side is attenuated
				lf = (it.pan_position > 0) ? 32768 - int'(it.pan_position) : 32768;
				rf = (it.pan_position < 0) ? 32768 + int'(it.pan_position) : 32768;
				v_base[slot] = it.wave_address;
				v_length[slot] = it.wave_frames;
				v_stereo[slot] = it.wave_is_stereo;
				v_start[slot] = it.start_at_frame;
				v_cursor[slot] = '0;
				v_left_gain[slot] = 16'((gain * lf) >> 15);
				v_right_gain[slot] = 16'((gain * rf) >> 15);
				v_loop[slot] = it.loop_enable;
				v_active[slot] = 1'b1;
			end
			pvm_pkg::CMD_STOP: begin
				for (int v = 0; v < VOICES; v++) v_active[v] = 1'b0;
			end
			pvm_pkg::CMD_RENDER: begin
				nch = (out_channels >= 2) ? 2 : 1;
				for (int v = 0; v < VOICES; v++) begin
					if (!v_active[v] || it.frame_index < v_start[v]) continue;
					if (v_cursor[v] >= v_length[v]) begin
						if (!v_loop[v]) begin
							v_active[v] = 1'b0;
							continue;
						end
						v_cursor[v] = '0;
					end
					for (int c = 0; c < nch; c++) begin
						a = wave_addr_of(v, v_cursor[v], v_stereo[v] ? c : 0);
						smp = longint'($signed(wave_mem[a]));
						g = (c == 0) ? longint'(v_left_gain[v]) : longint'(v_right_gain[v]);
						acc[c] += (smp * g) >>> 14;   // floor toward minus infinity
					end
					v_cursor[v] = v_cursor[v] + 17'd1;
				end
				r.left_sample = clamp16(acc[0], clip);
				if (nch == 2) r.right_sample = clamp16(acc[1], clip);
				r.clipped = clip;
			end
			default: begin
				wave_mem[it.wave_address] = it.wave_word;
				wave_written[it.wave_address] = 1'b1;
			end
		endcase
		cnt = 0;
		for (int v = 0; v < VOICES; v++) cnt += v_active[v];
		r.active_voice_count = 5'(cnt);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		mix_frame_t want;
		if (arst_n && result_valid) begin
			if (pending_frames.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_frames.pop_front();
				if (left_sample !== want.left_sample)
					report_mismatch("left_sample", left_sample, want.left_sample);
				if (right_sample !== want.right_sample)
					report_mismatch("right_sample", right_sample, want.right_sample);
				if (active_voice_count !== want.active_voice_count)
					report_mismatch("active_voice_count", active_voice_count,
						want.active_voice_count);
				if (clipped !== want.clipped)
					report_mismatch("clipped", clipped, want.clipped);
				if (want.clipped) n_clip++;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic mixer_cmd_t random_cmd(pvm_pkg::cmd_t op);
		mixer_cmd_t it;
		// every field carries noise; the block must ignore what op does not use
		it.command = op;
		it.frame_index = $urandom;
		it.wave_address = 16'($urandom);
		it.wave_frames = 17'($urandom);
		it.wave_is_stereo = 1'($urandom);
		it.start_at_frame = $urandom;
		it.voice_gain = 16'($urandom);
		it.pan_position = 16'($urandom);
		it.loop_enable = 1'($urandom);
		it.wave_word = 16'($urandom);
		return it;
	endfunction

	// random burst of idle cycles on the command side
	task automatic maybe_pause();
		if (allow_gaps && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
	endtask

	// one command transaction; start stays high until the caller pauses
	task automatic send_cmd(mixer_cmd_t it);
		@(negedge clk);
		start = 1'b1;
		command = it.command;
		frame_index = it.frame_index;
		wave_address = it.wave_address;
		wave_frames = it.wave_frames;
		wave_is_stereo = it.wave_is_stereo;
		start_at_frame = it.start_at_frame;
		voice_gain = it.voice_gain;
		pan_position = it.pan_position;
		loop_enable = it.loop_enable;
		wave_word = it.wave_word;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		pending_frames.push_back(mix_command(it));
		case (it.command)
			pvm_pkg::CMD_PLAY:   n_play++;
			pvm_pkg::CMD_STOP:   n_stop++;
			pvm_pkg::CMD_RENDER: n_render++;
			default:             n_write++;
		endcase
	endtask

	task automatic write_word(logic [15:0] addr, logic signed [15:0] word);
		mixer_cmd_t it;
		it = random_cmd(pvm_pkg::CMD_WRITE);
		it.wave_address = addr;
		it.wave_word = word;
		maybe_pause();
		send_cmd(it);
	endtask

	task automatic play_voice(logic [15:0] base, logic [16:0] frames, logic stereo,
			logic [31:0] first, logic [15:0] gain, logic signed [15:0] pan, logic lp);
		mixer_cmd_t it;
		it = random_cmd(pvm_pkg::CMD_PLAY);
		it.wave_address = base;
		it.wave_frames = frames;
		it.wave_is_stereo = stereo;
		it.start_at_frame = first;
		it.voice_gain = gain;
		it.pan_position = pan;
		it.loop_enable = lp;
		maybe_pause();
		send_cmd(it);
	endtask

	// a render never reads a word that was never written: fill the words
	// the next render would fetch before sending it
	task automatic render_frame(logic [31:0] frame);
		mixer_cmd_t it;
		logic [16:0] cur;
		logic [15:0] a;
		int nch;
		nch = (out_channels >= 2) ? 2 : 1;
		for (int v = 0; v < VOICES; v++) begin
			if (!v_active[v] || frame < v_start[v]) continue;
			cur = v_cursor[v];
			if (cur >= v_length[v]) begin
				if (!v_loop[v]) continue;
				cur = '0;
			end
			for (int c = 0; c < nch; c++) begin
				a = wave_addr_of(v, cur, v_stereo[v] ? c : 0);
				if (!wave_written[a]) write_word(a, 16'($urandom));
			end
		end
		it = random_cmd(pvm_pkg::CMD_RENDER);
		it.frame_index = frame;
		maybe_pause();
		send_cmd(it);
	endtask

	task automatic stop_all();
		maybe_pause();
		send_cmd(random_cmd(pvm_pkg::CMD_STOP));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (pending_frames.size() != 0) @(negedge clk);
	endtask

	// channel register is only touched with nothing in flight
	task automatic set_channels(logic [1:0] value);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_data = value;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		out_channels = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_idle_after_reset();
		render_frame(32'd0);
		stop_all();
		render_frame(32'hffff_ffff);
	endtask

	task automatic test_extremes();
		write_word(16'h0000, 16'sh7fff);
		write_word(16'h0001, -16'sh8000);
		write_word(16'hffff, -16'sh8000);
		// full gain, hard pans and centre on extreme samples
		play_voice(16'h0000, 17'd2, 1'b1, 32'd0, 16'hffff, 16'sh7fff, 1'b0);
		play_voice(16'h0000, 17'd1, 1'b0, 32'd0, 16'hffff, -16'sh8000, 1'b1);
		play_voice(16'hffff, 17'h10000, 1'b1, 32'd0, 16'h4000, 16'sh0000, 1'b0);
		play_voice(16'h0001, 17'd0, 1'b0, 32'd0, 16'h0000, 16'sh0001, 1'b1);
		// starts only at the last frame index
		play_voice(16'h0000, 17'd3, 1'b0, 32'hffff_ffff, 16'hffff, -16'sh0001, 1'b0);
		render_frame(32'd0);
		render_frame(32'd1);
		render_frame(32'd2);
		render_frame(32'hffff_ffff);
		render_frame(32'hffff_ffff);
		stop_all();
		render_frame(32'd5);
	endtask

	task automatic test_voice_steal();
		write_word(16'h0100, 16'sh1234);
		for (int i = 0; i < 19; i++)
			play_voice(16'h0100, 17'd0, 1'b0, 32'd0, 16'($urandom), 16'($urandom), 1'b1);
		render_frame(32'd10);
		stop_all();
	endtask

	task automatic test_channel_modes();
		logic [1:0] modes [4];
		modes = '{2'd1, 2'd0, 2'd3, 2'd2};
		foreach (modes[m]) begin
			set_channels(modes[m]);
			write_word(16'h0200, 16'sh4000);
			write_word(16'h0201, -16'sh2000);
			play_voice(16'h0200, 17'd1, 1'b1, 32'd0, 16'h8000, -16'sh4000, 1'b1);
			render_frame(32'd0);
			render_frame(32'd1);
			stop_all();
		end
	endtask

	function automatic logic [16:0] pick_length();
		case ($urandom_range(0, 19))
			0:       return 17'd0;
			1:       return 17'h10000;
			2:       return 17'($urandom);
			default: return 17'($urandom_range(1, 48));
		endcase
	endfunction

	function automatic logic [31:0] pick_start();
		case ($urandom_range(0, 15))
			0:       return 32'd0;
			1:       return 32'hffff_ffff;
			2:       return $urandom;
			default: return play_head + $urandom_range(0, 6);
		endcase
	endfunction

	// renders on an advancing frame counter among writes, with voices coming and going
	task automatic test_random_mix(int count, bit pause_midway);
		mixer_cmd_t it;
		int sel;
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2) wait_drained();
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				if ($urandom_range(0, 29) == 0) play_head = $urandom;
				else play_head = play_head + 1;
				render_frame(play_head);
			end else if (sel < 65) begin
				play_voice(16'($urandom), pick_length(), 1'($urandom), pick_start(),
					16'($urandom), 16'($urandom), 1'($urandom));
			end else if (sel < 97) begin
				it = random_cmd(pvm_pkg::CMD_WRITE);
				maybe_pause();
				send_cmd(it);
			end else begin
				stop_all();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		for (int a = 0; a < 65536; a++) begin
			wave_mem[a] = '0;
			wave_written[a] = 1'b0;
		end
		for (int v = 0; v < VOICES; v++) begin
			v_base[v] = '0;
			v_length[v] = '0;
			v_stereo[v] = 1'b0;
			v_start[v] = '0;
			v_cursor[v] = '0;
			v_left_gain[v] = '0;
			v_right_gain[v] = '0;
			v_loop[v] = 1'b0;
			v_active[v] = 1'b0;
		end
		steal_ptr = '0;
		out_channels = 2'd2;
		mismatches = 0;
		quiet_cycles = 0;
		play_head = '0;
		allow_gaps = 1'b1;
		start = 1'b0;
		command = pvm_pkg::CMD_STOP;
		frame_index = '0;
		wave_address = '0;
		wave_frames = '0;
		wave_is_stereo = 1'b0;
		start_at_frame = '0;
		voice_gain = '0;
		pan_position = '0;
		loop_enable = 1'b0;
		wave_word = '0;
		cfg_valid = 1'b0;
		cfg_data = 2'd2;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_after_reset();
		test_extremes();
		test_voice_steal();
		test_channel_modes();
		set_channels(2'd2);
		test_random_mix(330, 1'b1);
		set_channels(2'd1);
		test_random_mix(300, 1'b0);
		set_channels(2'd0);
		test_random_mix(200, 1'b0);
		set_channels(2'd3);
		test_random_mix(300, 1'b0);
		set_channels(2'd2);
		// last stretch back to back, no idling
		allow_gaps = 1'b0;
		test_random_mix(200, 1'b0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d renders, %0d plays (%0d steals), %0d writes, %0d stops",
			n_render, n_play, n_steal, n_write, n_stop);
		$display("%0d clipped frames, channel modes 0 to 3, %0d mismatches",
			n_clip, mismatches);
		if (mismatches == 0 && pending_frames.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
src/pvm_pkg.sv
src/pvm_ctrl.sv
src/pvm_datapath.sv
src/panned_voice_mixer_unit.sv
tb/panned_voice_mixer_unit_tb.sv
